>>> hw/rtl/spadj_pkg.sv
// Shared types and constants for the setpoint adjust block.
package spadj_pkg;

  localparam int SP_W    = 10;
  localparam int STEP_W  = 7;
  localparam int TICK_W  = 32;
  localparam int ACCEL_W = 16;
  localparam int VAL_W   = 12;
  localparam int MAG_W   = 11;
  localparam int LIM_W   = 10;

  typedef enum logic [2:0] {
    BTN_NONE,
    BTN_BOTH,
    BTN_BOTH_LONG,
    BTN_BACK_SHORT,
    BTN_BACK_LONG,
    BTN_FRONT_SHORT,
    BTN_FRONT_LONG,
    BTN_OTHER
  } btn_e;

  typedef enum logic [1:0] {
    REASON_STAY,
    REASON_BOTH,
    REASON_IDLE
  } reason_e;

  typedef enum logic [2:0] {
    CFG_SHORT_STEP,
    CFG_LONG_STEP,
    CFG_REVERSE,
    CFG_FAHRENHEIT,
    CFG_LOW_LIMIT_C,
    CFG_HIGH_LIMIT_C,
    CFG_LOW_LIMIT_F,
    CFG_HIGH_LIMIT_F
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  dividend;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] rem;
  } div_resp_t;

endpackage

>>> hw/rtl/spadj_rem.sv
// Bit-serial restoring divider that returns the remainder of a magnitude by the step.
module spadj_rem import spadj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  output div_resp_t resp_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MAG_W-1:0]  num_q, num_d;
  logic [STEP_W-1:0] div_q, div_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;

  always_comb begin
    trial  = {rem_q, num_q[MAG_W-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MAG_W);
      num_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[STEP_W-1:0];
      end else begin
        rem_d = trial[STEP_W-1:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign resp_o.done = done_q;
  assign resp_o.rem  = rem_q;

endmodule

>>> hw/rtl/setpoint_adjust_with_autorepeat.sv
// Top level of the setpoint adjust block with accelerating auto-repeat.
// An event that moves the setpoint passes through decode, the remainder unit, apply and the
// output register load; events that leave the setpoint alone go from decode to the load, which
// waits while the output register is full. A new event is taken once the sequencer is back in
// idle, while an earlier result may still wait in the output register.
// Reset is asynchronous and active low; it restores the register defaults and the setpoint.
module setpoint_adjust_with_autorepeat import spadj_pkg::*; #(
  parameter int REPEAT_INTERVAL_MAX = 300,
  parameter int REPEAT_INTERVAL_MIN = 100,
  parameter int REPEAT_ACCEL_STEP   = 33,
  parameter int IDLE_TIMEOUT_TICKS  = 1500,
  parameter int DEFAULT_SETPOINT    = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // now_ticks [31:0], last_press_ticks [63:32]
  input  logic [2:0]  s_axis_tuser,   // button [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // setpoint [9:0], exit_reason [11:10], zeros above
);

  localparam int                 ACCEL_SPAN  = REPEAT_INTERVAL_MAX - REPEAT_INTERVAL_MIN;
  localparam logic [ACCEL_W-1:0] ACCEL_FLOOR = ACCEL_W'(ACCEL_SPAN);
  localparam logic [ACCEL_W-1:0] ACCEL_INC   = ACCEL_W'(REPEAT_ACCEL_STEP);
  localparam logic [TICK_W-1:0]  RPT_MAX     = TICK_W'(REPEAT_INTERVAL_MAX);
  localparam logic [TICK_W-1:0]  IDLE_MAX    = TICK_W'(IDLE_TIMEOUT_TICKS);
  localparam logic [SP_W-1:0]    SP_RESET    = SP_W'(DEFAULT_SETPOINT);

  logic [STEP_W-1:0] short_step_q, long_step_q;
  logic              reverse_q, fahrenheit_q;
  logic [LIM_W-1:0]  low_c_q, high_c_q, low_f_q, high_f_q;

  state_e              state_q, state_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [TICK_W-1:0]   timer_q, timer_d;
  logic [ACCEL_W-1:0]  accel_q, accel_d;
  btn_e                btn_q;
  logic [TICK_W-1:0]   now_q, last_q;
  logic                neg_q, neg_d;
  logic [MAG_W-1:0]    abs_q, abs_d;
  reason_e             reason_q, reason_d;
  logic                out_valid_q, out_valid_d;
  logic [SP_W-1:0]     out_sp_q, out_sp_d;
  reason_e             out_reason_q, out_reason_d;

  logic                in_xfer;
  logic                out_free;
  logic                due;
  logic                dir_neg;
  logic [STEP_W-1:0]   mag;
  logic [ACCEL_W-1:0]  accel_new;
  logic signed [VAL_W-1:0] moved;
  logic [MAG_W-1:0]    trunc_mag;
  logic signed [VAL_W-1:0] trunc_val;
  logic signed [VAL_W-1:0] lo_s, hi_s;
  div_req_t            div_req;
  div_resp_t           div_resp;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_step_q <= STEP_W'(1);
      long_step_q  <= STEP_W'(10);
      reverse_q    <= 1'b0;
      fahrenheit_q <= 1'b0;
      low_c_q      <= LIM_W'(10);
      high_c_q     <= LIM_W'(450);
      low_f_q      <= LIM_W'(50);
      high_f_q     <= LIM_W'(850);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_SHORT_STEP:   short_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_LONG_STEP:    long_step_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_REVERSE:      reverse_q    <= cfg_wdata_i[0];
        CFG_FAHRENHEIT:   fahrenheit_q <= cfg_wdata_i[0];
        CFG_LOW_LIMIT_C:  low_c_q      <= cfg_wdata_i;
        CFG_HIGH_LIMIT_C: high_c_q     <= cfg_wdata_i;
        CFG_LOW_LIMIT_F:  low_f_q      <= cfg_wdata_i;
        CFG_HIGH_LIMIT_F: high_f_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (btn_q inside {BTN_BOTH, BTN_BOTH_LONG} || mag == '0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_resp.done) state_d = ST_APPLY;
      end
      ST_APPLY:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Button decode and repeat timing.
  always_comb begin
    due       = (now_q - timer_q + TICK_W'(accel_q)) > RPT_MAX;
    mag       = '0;
    dir_neg   = 1'b0;
    accel_new = accel_q;
    timer_d   = timer_q;
    case (btn_q)
      BTN_NONE: accel_new = '0;
      BTN_BACK_SHORT: begin
        mag     = short_step_q;
        dir_neg = 1'b1;
      end
      BTN_FRONT_SHORT: mag = short_step_q;
      BTN_BACK_LONG, BTN_FRONT_LONG: begin
        dir_neg = (btn_q == BTN_BACK_LONG);
        if (due) begin
          timer_d   = now_q;
          accel_new = accel_q + ACCEL_INC;
          mag       = long_step_q;
        end
      end
      default: ;
    endcase
    if (int'(accel_new) > ACCEL_SPAN) accel_new = ACCEL_FLOOR;
  end

  // Datapath and output register.
  always_comb begin
    accel_d      = accel_q;
    sp_d         = sp_q;
    neg_d        = neg_q;
    abs_d        = abs_q;
    reason_d     = reason_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_sp_d     = out_sp_q;
    out_reason_d = out_reason_q;
    div_req      = '0;
    moved        = '0;
    trunc_mag    = abs_q - MAG_W'(div_resp.rem);
    trunc_val    = neg_q ? -$signed({1'b0, trunc_mag}) : $signed({1'b0, trunc_mag});
    lo_s         = $signed({2'b00, (fahrenheit_q ? low_f_q : low_c_q)});
    hi_s         = $signed({2'b00, (fahrenheit_q ? high_f_q : high_c_q)});
    case (state_q)
      ST_CALC: begin
        if (dir_neg ^ reverse_q) begin
          moved = $signed({2'b00, sp_q}) - $signed({5'b00000, mag});
        end else begin
          moved = $signed({2'b00, sp_q}) + $signed({5'b00000, mag});
        end
        neg_d = moved[VAL_W-1];
        abs_d = moved[VAL_W-1] ? MAG_W'(-moved) : moved[MAG_W-1:0];
        if (btn_q inside {BTN_BOTH, BTN_BOTH_LONG}) begin
          reason_d = REASON_BOTH;
        end else begin
          accel_d  = accel_new;
          reason_d = ((now_q - last_q) > IDLE_MAX) ? REASON_IDLE : REASON_STAY;
          div_req.start    = (mag != '0);
          div_req.dividend = abs_d;
          div_req.divisor  = mag;
        end
      end
      ST_APPLY: begin
        if (trunc_val > hi_s) begin
          sp_d = hi_s[SP_W-1:0];
        end else if (trunc_val < lo_s) begin
          sp_d = lo_s[SP_W-1:0];
        end else begin
          sp_d = trunc_val[SP_W-1:0];
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sp_d     = sp_q;
          out_reason_d = reason_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= SP_RESET;
      timer_q     <= '0;
      accel_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      timer_q     <= (state_q == ST_CALC && !(btn_q inside {BTN_BOTH, BTN_BOTH_LONG}))
                     ? timer_d : timer_q;
      accel_q     <= accel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      btn_q  <= btn_e'(s_axis_tuser);
      now_q  <= s_axis_tdata[31:0];
      last_q <= s_axis_tdata[63:32];
    end
    neg_q        <= neg_d;
    abs_q        <= abs_d;
    reason_q     <= reason_d;
    out_sp_q     <= out_sp_d;
    out_reason_q <= out_reason_d;
  end

  spadj_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_reason_q, out_sp_q};

`ifndef SYNTH
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_resp.done |-> state_q == ST_DIV)
    else $error("remainder finished outside the divide state");

  a_timer_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(timer_q) |-> $past(state_q) == ST_CALC)
    else $error("repeat timer changed outside decode");
`endif

endmodule
